// File: src/fog_pkg.sv
// fog_pkg: shared types, codes and constants of the footprint occupancy grid.
// Used by fog_grid and footprint_occupancy_grid; depends on nothing.

package fog_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int MAX_SIDE_DEF      = 256;
    localparam int MAX_OWNERS_DEF    = 4096;
    localparam int MAX_FOOTPRINT_DEF = 32;

    // Fixed by the item field widths
    localparam int OWNER_W    = 12;
    localparam int CFG_DATA_W = 9;
    localparam int YARD_SIDE  = 32;
    localparam int YARD_AW    = 5;
    // Footprint coordinate: 8-bit corner plus an offset below 64
    localparam int COORD_W    = 9;

    // Immobile owners get their corner rounded down to even
    localparam logic [23:0] EVEN_MASK = 24'hfffffe;

    // Function codes
    localparam logic [2:0] FN_ADD       = 3'd0;
    localparam logic [2:0] FN_LOAD_YARD = 3'd1;
    localparam logic [2:0] FN_ADD_YARD  = 3'd2;
    localparam logic [2:0] FN_REMOVE    = 3'd3;
    localparam logic [2:0] FN_CLEAN     = 3'd4;
    localparam logic [2:0] FN_QUERY     = 3'd5;

    // Configuration register indexes
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    // Grid access operations
    localparam logic [2:0] GOP_CLEAR  = 3'd0;
    localparam logic [2:0] GOP_STAMP  = 3'd1;
    localparam logic [2:0] GOP_REMOVE = 3'd2;
    localparam logic [2:0] GOP_CLEAN  = 3'd3;
    localparam logic [2:0] GOP_READ   = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] owner_id;
        logic [7:0]  corner_x;
        logic [7:0]  corner_z;
        logic [5:0]  size_x;
        logic [5:0]  size_z;
        logic        immobile;
        logic        is_static;
        logic [4:0]  yard_row;
        logic [31:0] yard_bits;
        logic [15:0] cell_index;
    } t_item;

    typedef struct packed {
        logic [11:0] found_owner;
        logic [16:0] cleared_count;
        logic        terrain_changed;
        logic [7:0]  change_min_x;
        logic [7:0]  change_min_z;
        logic [8:0]  change_end_x;
        logic [8:0]  change_end_z;
    } t_result;

    // Per-cycle command from the sequencer to the grid
    typedef struct packed {
        logic               valid;
        logic [2:0]         op;
        logic               stamp_ok;
        logic               count_clr;
        logic [OWNER_W-1:0] owner;
    } t_grid_ctl;

endpackage

// File: src/footprint_occupancy_grid.sv
// footprint_occupancy_grid: top level, sequencer, yard and corner memories.
// Depends on fog_pkg and fog_grid.
// Add and remove walk the footprint and clean scans the whole map, one cell per cycle through
// the grid; an add or remove of zero size skips the walk.
// busy is high while an item runs and drops in the strobe cycle; results cannot be stalled.
// Reset (sync, active low) starts a clearing pass over all MAX_SIDE*MAX_SIDE cells (65536
// at defaults) with busy high; config writes are taken during it.

module footprint_occupancy_grid #(
    parameter int MAX_SIDE      = fog_pkg::MAX_SIDE_DEF,
    parameter int MAX_OWNERS    = fog_pkg::MAX_OWNERS_DEF,
    parameter int MAX_FOOTPRINT = fog_pkg::MAX_FOOTPRINT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fog_pkg::t_item                i_item,
    output logic                          o_done,
    output fog_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [fog_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Sizes
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int SLOT_W   = $clog2(MAX_OWNERS);
    localparam int FP_W     = $clog2(MAX_FOOTPRINT + 1);
    localparam int RB_W     = fog_pkg::COORD_W + SIDE_W;
    localparam int SIDE_RST = (MAX_SIDE < 256) ? MAX_SIDE : 256;
    // owner mod MAX_OWNERS: floor reciprocal, quotient low by at most one
    localparam int RECIP    = (1 << 24) / MAX_OWNERS;

    // Sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SLOT   = 4'd2;
    localparam logic [3:0] S_CORNER = 4'd3;
    localparam logic [3:0] S_SETUP  = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_QUERY  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0]  r_state;

    // Map registers and derived cell count
    logic [SIDE_W-1:0] r_w;
    logic [SIDE_W-1:0] r_h;
    logic [SIDE_W-1:0] cfg_side;
    logic [ADDR_W:0]   cell_count;
    logic [ADDR_W:0]   r_cell_count;

    // Latched item
    logic [2:0]                  r_func;
    logic [fog_pkg::OWNER_W-1:0] r_owner;
    logic [7:0]                  r_cx;
    logic [7:0]                  r_cz;
    logic [FP_W-1:0]             r_sx;
    logic [FP_W-1:0]             r_sz;
    logic                        r_static;
    logic [ADDR_W-1:0]           r_q_addr;
    logic                        r_q_in;
    logic [32:0]                 r_prod;

    // Walker
    logic [FP_W-1:0]   r_dx;
    logic [FP_W-1:0]   r_dz;
    logic [RB_W-1:0]   r_row_base;
    logic [ADDR_W:0]   r_scan;
    logic [FP_W-1:0]   n_dx;
    logic [FP_W-1:0]   n_dz;
    logic [RB_W-1:0]   n_row_base;
    logic [ADDR_W:0]   n_scan;
    logic              walk_done;
    logic              last_dx;
    logic              last_dz;
    logic [fog_pkg::COORD_W-1:0] cell_x;
    logic [fog_pkg::COORD_W-1:0] cell_z;
    logic              in_map;
    logic              yard_ok;

    // Memories beside the grid
    logic [31:0] yard_mem [fog_pkg::YARD_SIDE];
    logic [31:0] r_yard_data;
    logic [15:0] corner_mem [MAX_OWNERS];
    logic [15:0] r_corner_rd;
    logic [8:0]  quo;
    logic [31:0] rem;
    logic [31:0] rem_fix;
    logic [SLOT_W-1:0] slot;

    // Grid interface
    fog_pkg::t_grid_ctl          grid_ctl;
    logic [ADDR_W-1:0]           grid_addr;
    logic [fog_pkg::OWNER_W-1:0] grid_rdata;
    logic [ADDR_W:0]             grid_count;

    // Result
    logic             r_out_valid;
    fog_pkg::t_result r_result;
    fog_pkg::t_result n_result;
    logic             changed;

    logic accept;
    logic is_add;
    logic is_clean;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign is_add   = (r_func == fog_pkg::FN_ADD) || (r_func == fog_pkg::FN_ADD_YARD);
    assign is_clean = (r_func == fog_pkg::FN_CLEAN);

    // Cell count of the current map, valid right after a size write
    assign cell_count = (ADDR_W + 1)'(r_w) * (ADDR_W + 1)'(r_h);

    // Config value saturates to 1..MAX_SIDE
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_side = SIDE_W'(1);
        end else if (32'(i_cfg_data) > MAX_SIDE) begin
            cfg_side = SIDE_W'(MAX_SIDE);
        end else begin
            cfg_side = SIDE_W'(i_cfg_data);
        end
    end

    // Owner slot, worked out in S_SLOT from the product taken at accept
    always_comb begin
        quo     = r_prod[32:24];
        rem     = 32'(r_owner) - 32'(quo) * 32'(MAX_OWNERS);
        rem_fix = (rem >= 32'(MAX_OWNERS)) ? rem - 32'(MAX_OWNERS) : rem;
        slot    = SLOT_W'(rem_fix);
    end

    // Footprint cell under the walker
    always_comb begin
        cell_x  = fog_pkg::COORD_W'(r_cx) + fog_pkg::COORD_W'(r_dx);
        cell_z  = fog_pkg::COORD_W'(r_cz) + fog_pkg::COORD_W'(r_dz);
        in_map  = (32'(cell_x) < 32'(r_w)) && (32'(cell_z) < 32'(r_h));
        // yard mask covers the first 32 rows and columns of the footprint only
        yard_ok = (32'(r_dx) < fog_pkg::YARD_SIDE) && (32'(r_dz) < fog_pkg::YARD_SIDE)
                  && r_yard_data[fog_pkg::YARD_AW'(r_dx)];
        last_dx = (r_dx == r_sx - FP_W'(1));
        last_dz = (r_dz == r_sz - FP_W'(1));
    end

    // Walker counters: clearing sweep, clean scan, footprint raster
    always_comb begin
        n_dx       = r_dx;
        n_dz       = r_dz;
        n_row_base = r_row_base;
        n_scan     = r_scan;
        walk_done  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_scan = r_scan + 1'b1;
            end
            S_SETUP: begin
                n_dx       = '0;
                n_dz       = '0;
                n_scan     = '0;
                n_row_base = RB_W'(r_cz) * RB_W'(r_w);
            end
            S_WALK: begin
                if (is_clean) begin
                    n_scan    = r_scan + 1'b1;
                    walk_done = (r_scan == r_cell_count - 1'b1);
                end else if (last_dx) begin
                    n_dx       = '0;
                    n_dz       = r_dz + FP_W'(1);
                    n_row_base = r_row_base + RB_W'(r_w);
                    walk_done  = last_dz;
                end else begin
                    n_dx = r_dx + FP_W'(1);
                end
            end
            default: begin
                n_scan = r_scan;
            end
        endcase
    end

    // Grid command for this cycle
    always_comb begin
        grid_ctl.valid     = 1'b0;
        grid_ctl.op        = fog_pkg::GOP_READ;
        grid_ctl.stamp_ok  = 1'b1;
        grid_ctl.count_clr = (r_state == S_SETUP);
        grid_ctl.owner     = r_owner;
        grid_addr          = ADDR_W'(r_row_base + RB_W'(cell_x));
        unique case (r_state)
            S_CLEAR: begin
                grid_ctl.valid = 1'b1;
                grid_ctl.op    = fog_pkg::GOP_CLEAR;
                grid_addr      = ADDR_W'(r_scan);
            end
            S_WALK: begin
                if (is_clean) begin
                    grid_ctl.valid = 1'b1;
                    grid_ctl.op    = fog_pkg::GOP_CLEAN;
                    grid_addr      = ADDR_W'(r_scan);
                end else begin
                    grid_ctl.valid = in_map;
                    if (r_func == fog_pkg::FN_REMOVE) begin
                        grid_ctl.op = fog_pkg::GOP_REMOVE;
                    end else begin
                        grid_ctl.op = fog_pkg::GOP_STAMP;
                    end
                    if (r_func == fog_pkg::FN_ADD_YARD) begin
                        grid_ctl.stamp_ok = yard_ok;
                    end
                end
            end
            S_QUERY: begin
                grid_ctl.valid = r_q_in;
                grid_addr      = r_q_addr;
            end
            default: begin
                grid_ctl.valid = 1'b0;
            end
        endcase
    end

    fog_grid #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (grid_ctl),
        .i_addr  (grid_addr),
        .o_rdata (grid_rdata),
        .o_count (grid_count)
    );

    // Yard rows: written on load, read one row ahead of the walker
    always_ff @(posedge i_clk) begin
        if (accept && (i_item.func == fog_pkg::FN_LOAD_YARD)) begin
            yard_mem[i_item.yard_row] <= i_item.yard_bits;
        end
        r_yard_data <= yard_mem[fog_pkg::YARD_AW'(n_dz)];
    end

    // Owner corners: add stores, remove reads back
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SLOT) && is_add) begin
            corner_mem[slot] <= {r_cz, r_cx};
        end
        r_corner_rd <= corner_mem[slot];
    end

    // Result assembly
    always_comb begin
        changed = r_static && (is_add || (r_func == fog_pkg::FN_REMOVE));
        n_result.found_owner     = ((r_func == fog_pkg::FN_QUERY) && r_q_in) ? grid_rdata : '0;
        n_result.cleared_count   = is_clean ? 17'(grid_count) : '0;
        n_result.terrain_changed = changed;
        n_result.change_min_x    = changed ? r_cx : '0;
        n_result.change_min_z    = changed ? r_cz : '0;
        n_result.change_end_x    = changed ? 9'(r_cx) + 9'(r_sx) : '0;
        n_result.change_end_z    = changed ? 9'(r_cz) + 9'(r_sz) : '0;
    end

    // Walker datapath registers
    always_ff @(posedge i_clk) begin
        r_dx       <= n_dx;
        r_dz       <= n_dz;
        r_row_base <= n_row_base;
        r_cell_count <= cell_count;
        if (r_state == S_FIN) begin
            r_result <= n_result;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_item.func;
            r_owner  <= i_item.owner_id;
            r_static <= i_item.is_static;
            if (i_item.immobile) begin
                r_cx <= i_item.corner_x & fog_pkg::EVEN_MASK[7:0];
                r_cz <= i_item.corner_z & fog_pkg::EVEN_MASK[7:0];
            end else begin
                r_cx <= i_item.corner_x;
                r_cz <= i_item.corner_z;
            end
            r_sx <= (32'(i_item.size_x) > MAX_FOOTPRINT) ? FP_W'(MAX_FOOTPRINT)
                                                          : FP_W'(i_item.size_x);
            r_sz <= (32'(i_item.size_z) > MAX_FOOTPRINT) ? FP_W'(MAX_FOOTPRINT)
                                                          : FP_W'(i_item.size_z);
            r_q_addr <= ADDR_W'(i_item.cell_index);
            r_q_in   <= (32'(i_item.cell_index) < 32'(cell_count));
            r_prod   <= 33'(i_item.owner_id) * 33'(RECIP);
        end else if (r_state == S_CORNER) begin
            // remove walks at the stored corner
            r_cx <= r_corner_rd[7:0];
            r_cz <= r_corner_rd[15:8];
        end
    end

    // Sequencer, config registers, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
            r_w         <= SIDE_W'(SIDE_RST);
            r_h         <= SIDE_W'(SIDE_RST);
        end else begin
            r_scan      <= n_scan;
            r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    fog_pkg::CFG_MAP_WIDTH:  r_w <= cfg_side;
                    fog_pkg::CFG_MAP_HEIGHT: r_h <= cfg_side;
                    default:                 r_w <= r_w;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_scan == (ADDR_W + 1)'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        priority case (i_item.func)
                            fog_pkg::FN_ADD,
                            fog_pkg::FN_ADD_YARD,
                            fog_pkg::FN_REMOVE: r_state <= S_SLOT;
                            fog_pkg::FN_CLEAN:  r_state <= S_SETUP;
                            fog_pkg::FN_QUERY:  r_state <= S_QUERY;
                            default:            r_state <= S_FIN;
                        endcase
                    end
                end
                S_SLOT: begin
                    r_state <= is_add ? S_SETUP : S_CORNER;
                end
                S_CORNER: begin
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    if (!is_clean && ((r_sx == '0) || (r_sz == '0))) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (walk_done) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_QUERY: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_out_valid;
    assign o_result = r_result;

    // Checks
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !grid_ctl.valid)
        else $error("grid accessed while idle");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == S_FIN))
        else $error("result strobe without finishing an item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_walk_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && grid_ctl.valid && !is_clean)
            |-> (32'(grid_addr) < 32'(r_cell_count)))
        else $error("footprint address beyond the map");

endmodule

// File: src/fog_grid.sv
// fog_grid: cell owner memory with a registered read and a write-back stage.
// Depends on fog_pkg (t_grid_ctl, GOP_* codes, OWNER_W).

module fog_grid #(
    parameter int DEPTH  = fog_pkg::MAX_SIDE_DEF * fog_pkg::MAX_SIDE_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fog_pkg::t_grid_ctl          i_ctl,
    input  logic [ADDR_W-1:0]           i_addr,
    output logic [fog_pkg::OWNER_W-1:0] o_rdata,
    output logic [ADDR_W:0]             o_count
);

    logic [fog_pkg::OWNER_W-1:0] mem [DEPTH];

    logic                        r_b_valid;
    logic [2:0]                  r_b_op;
    logic                        r_b_ok;
    logic [fog_pkg::OWNER_W-1:0] r_b_owner;
    logic [ADDR_W-1:0]           r_b_addr;
    logic [fog_pkg::OWNER_W-1:0] r_rdata;
    logic [ADDR_W:0]             r_count;
    logic [ADDR_W:0]             n_count;

    logic                        we;
    logic [fog_pkg::OWNER_W-1:0] wdata;
    logic                        hit;
    logic                        cnt_inc;

    // write-back decision on the data read in the previous cycle
    always_comb begin
        hit     = (r_rdata == r_b_owner);
        we      = 1'b0;
        wdata   = '0;
        cnt_inc = 1'b0;
        unique case (r_b_op)
            fog_pkg::GOP_CLEAR: begin
                we = 1'b1;
            end
            fog_pkg::GOP_STAMP: begin
                we    = (r_rdata == '0) && r_b_ok;
                wdata = r_b_owner;
            end
            fog_pkg::GOP_REMOVE: begin
                we = hit;
            end
            fog_pkg::GOP_CLEAN: begin
                we      = hit;
                cnt_inc = hit;
            end
            default: begin
                we = 1'b0;
            end
        endcase
        we      = we & r_b_valid;
        cnt_inc = cnt_inc & r_b_valid;
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.count_clr) begin
            n_count = '0;
        end else if (cnt_inc) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_b_addr] <= wdata;
        end
        if (i_ctl.valid && (i_ctl.op != fog_pkg::GOP_CLEAR)) begin
            r_rdata <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_op    <= i_ctl.op;
        r_b_ok    <= i_ctl.stamp_ok;
        r_b_owner <= i_ctl.owner;
        r_b_addr  <= i_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_count   <= '0;
        end else begin
            r_b_valid <= i_ctl.valid;
            r_count   <= n_count;
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

endmodule

// File: verif/fog_checker.sv
// fog_checker: watches the item, result and register ports of the footprint occupancy
// grid, predicts every result and compares it. Depends on fog_pkg only.

module fog_checker
    import fog_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_item                 i_item,
    input  logic                  i_done,
    input  t_result               i_result,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_errors
);

    typedef enum logic [1:0] {
        WALK_STAMP,
        WALK_YARD,
        WALK_CLEAR
    } t_walk;

    // Shadow state of the grid
    logic [OWNER_W-1:0] cell_map   [MAX_SIDE_DEF*MAX_SIDE_DEF];
    logic [31:0]        yard_map   [YARD_SIDE];
    logic [15:0]        corner_map [MAX_OWNERS_DEF];
    int unsigned        grid_w;
    int unsigned        grid_h;

    t_result            expected_q [$];
    int                 n_errors  = 0;
    int                 n_results = 0;

    assign o_errors = n_errors;

    task automatic report_mismatch(string what);
        $display("MISMATCH result %0d: %s", n_results, what);
        n_errors++;
    endtask

    function automatic int unsigned clamp_side(logic [CFG_DATA_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
        return v;
    endfunction

    // Off-map cells are skipped; yard stamping only inside the 32x32 mask
    function automatic void walk_footprint(int unsigned cx, int unsigned cz,
                                           int unsigned sx, int unsigned sz,
                                           logic [OWNER_W-1:0] who, t_walk mode);
        int unsigned x;
        int unsigned z;
        int unsigned idx;
        for (int unsigned dz = 0; dz < sz; dz++) begin
            z = cz + dz;
            if (z >= grid_h) continue;
            for (int unsigned dx = 0; dx < sx; dx++) begin
                x = cx + dx;
                if (x >= grid_w) continue;
                idx = z * grid_w + x;
                if (mode == WALK_CLEAR) begin
                    if (cell_map[idx] == who) cell_map[idx] = '0;
                end else if (cell_map[idx] == '0) begin
                    if (mode == WALK_STAMP ||
                        (dz < YARD_SIDE && dx < YARD_SIDE && yard_map[dz][dx]))
                        cell_map[idx] = who;
                end
            end
        end
    endfunction

    function automatic t_result predict_item(t_item it);
        t_result     r;
        int unsigned cx;
        int unsigned cz;
        int unsigned sx;
        int unsigned sz;
        int unsigned slot;
        int unsigned cnt;
        r    = '0;
        cx   = it.corner_x;
        cz   = it.corner_z;
        sx   = (it.size_x > MAX_FOOTPRINT_DEF) ? MAX_FOOTPRINT_DEF : it.size_x;
        sz   = (it.size_z > MAX_FOOTPRINT_DEF) ? MAX_FOOTPRINT_DEF : it.size_z;
        slot = it.owner_id % MAX_OWNERS_DEF;
        cnt  = 0;
        case (it.func)
            FN_ADD, FN_ADD_YARD: begin
                if (it.immobile) begin
                    cx = cx & EVEN_MASK;
                    cz = cz & EVEN_MASK;
                end
                corner_map[slot] = 16'((cz << 8) | cx);
                walk_footprint(cx, cz, sx, sz, it.owner_id,
                               (it.func == FN_ADD) ? WALK_STAMP : WALK_YARD);
                r.terrain_changed = it.is_static;
            end
            FN_LOAD_YARD: begin
                yard_map[it.yard_row] = it.yard_bits;
            end
            FN_REMOVE: begin
                cx = corner_map[slot][7:0];
                cz = corner_map[slot][15:8];
                walk_footprint(cx, cz, sx, sz, it.owner_id, WALK_CLEAR);
                r.terrain_changed = it.is_static;
            end
            FN_CLEAN: begin
                for (int unsigned i = 0; i < grid_w * grid_h; i++) begin
                    if (cell_map[i] == it.owner_id) begin
                        cell_map[i] = '0;
                        cnt++;
                    end
                end
                r.cleared_count = 17'(cnt);
            end
            FN_QUERY: begin
                if (it.cell_index < grid_w * grid_h) r.found_owner = cell_map[it.cell_index];
            end
            default: ;
        endcase
        // rectangle is reported unclipped, end exclusive
        if (r.terrain_changed) begin
            r.change_min_x = 8'(cx);
            r.change_min_z = 8'(cz);
            r.change_end_x = 9'(cx + sx);
            r.change_end_z = 9'(cz + sz);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SIDE_DEF * MAX_SIDE_DEF; i++) cell_map[i] = '0;
            grid_w = MAX_SIDE_DEF;
            grid_h = MAX_SIDE_DEF;
            expected_q.delete();
        end else begin
            // a strobe and the next accept may share an edge: pop first
            if (i_done) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result strobe with no item outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (i_result.found_owner !== want.found_owner)
                        report_mismatch($sformatf("found_owner got %0d want %0d",
                                                  i_result.found_owner, want.found_owner));
                    if (i_result.cleared_count !== want.cleared_count)
                        report_mismatch($sformatf("cleared_count got %0d want %0d",
                                                  i_result.cleared_count, want.cleared_count));
                    if (i_result.terrain_changed !== want.terrain_changed)
                        report_mismatch($sformatf("terrain_changed got %0d want %0d",
                                                  i_result.terrain_changed,
                                                  want.terrain_changed));
                    if (i_result.change_min_x !== want.change_min_x)
                        report_mismatch($sformatf("change_min_x got %0d want %0d",
                                                  i_result.change_min_x, want.change_min_x));
                    if (i_result.change_min_z !== want.change_min_z)
                        report_mismatch($sformatf("change_min_z got %0d want %0d",
                                                  i_result.change_min_z, want.change_min_z));
                    if (i_result.change_end_x !== want.change_end_x)
                        report_mismatch($sformatf("change_end_x got %0d want %0d",
                                                  i_result.change_end_x, want.change_end_x));
                    if (i_result.change_end_z !== want.change_end_z)
                        report_mismatch($sformatf("change_end_z got %0d want %0d",
                                                  i_result.change_end_z, want.change_end_z));
                end
                n_results++;
            end
            if (i_start && !i_busy) expected_q.push_back(predict_item(i_item));
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAP_WIDTH) grid_w = clamp_side(i_cfg_data);
                else grid_h = clamp_side(i_cfg_data);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

// File: verif/footprint_occupancy_grid_tb.sv
// footprint_occupancy_grid_tb: drives items and map-size writes into the occupancy grid
// and gives the verdict. Depends on fog_pkg, fog_checker and footprint_occupancy_grid.

module footprint_occupancy_grid_tb;
    import fog_pkg::*;

    localparam int      CLK_PERIOD   = 10;
    localparam int      RESET_CYCLES = 8;
    localparam int      POOL_SIZE    = 16;
    // Extra cycles to wait after the last result
    localparam int      DRAIN_CYCLES = 64;
    // Timeout: the slowest legal run of this stimulus is the clearing pass, one full-grid
    // clean and ~600 items (a small-map clean the slowest of them) plus sender gaps;
    // the limit takes it several times over.
    localparam longint  LIMIT_CYCLES = 20_000_000;

    // func values the block does not decode
    localparam logic [2:0] FN_SPARE_LO = 3'd6;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    t_item                 item     = '0;
    logic                  cfg_we   = 1'b0;
    logic                  cfg_idx  = CFG_MAP_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  busy;
    logic                  done;
    t_result               result;
    int                    pending;
    int                    errors;

    // Stimulus bookkeeping: which owners have a stored corner, which yard rows
    // are loaded, and the map size the block is running with.
    bit                    corner_set  [MAX_OWNERS_DEF];
    bit                    yard_loaded [YARD_SIDE];
    logic [OWNER_W-1:0]    owner_pool  [POOL_SIZE];
    logic [5:0]            pool_sx     [POOL_SIZE];
    logic [5:0]            pool_sz     [POOL_SIZE];
    int unsigned           map_w = MAX_SIDE_DEF;
    int unsigned           map_h = MAX_SIDE_DEF;
    int unsigned           last_x = 0;
    int unsigned           last_z = 0;
    bit                    idle_on = 1'b1;

    always #(CLK_PERIOD / 2) clk = ~clk;

    footprint_occupancy_grid u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predicts and compares; hands back outstanding and failure counts
    fog_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (item),
        .i_done     (done),
        .i_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // Number of yard rows loaded contiguously from row 0; add-with-yard reads
    // rows 0..size_z-1, so its height never goes past this.
    function automatic int yard_prefix();
        int n;
        n = 0;
        while (n < YARD_SIDE && yard_loaded[n]) n++;
        return n;
    endfunction

    // Mostly small footprints to keep the walk short; a few saturate past 32
    function automatic logic [5:0] random_side();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2) return 6'd0;
        if (r < 72) return 6'($urandom_range(1, 8));
        if (r < 92) return 6'($urandom_range(9, 32));
        return 6'($urandom_range(33, 63));
    endfunction

    function automatic t_item cmd(logic [2:0] fn, logic [OWNER_W-1:0] who,
                                  logic [7:0] cx, logic [7:0] cz,
                                  logic [5:0] sx, logic [5:0] sz,
                                  logic imm, logic stat);
        t_item it;
        it           = '0;
        it.func      = fn;
        it.owner_id  = who;
        it.corner_x  = cx;
        it.corner_z  = cz;
        it.size_x    = sx;
        it.size_z    = sz;
        it.immobile  = imm;
        it.is_static = stat;
        return it;
    endfunction

    function automatic t_item yard_cmd(logic [4:0] row, logic [31:0] bits);
        t_item it;
        it           = '0;
        it.func      = FN_LOAD_YARD;
        it.yard_row  = row;
        it.yard_bits = bits;
        return it;
    endfunction

    function automatic t_item query_cmd(logic [15:0] idx);
        t_item it;
        it            = '0;
        it.func       = FN_QUERY;
        it.cell_index = idx;
        return it;
    endfunction

    // Random item: every field starts fully random (unused fields keep that),
    // then the fields the operation reads are shaped toward legal, colliding
    // traffic around a small pool of owners.
    function automatic t_item random_item();
        t_item        it;
        logic [127:0] raw;
        int unsigned  pick;
        int unsigned  p;
        int           prefix;
        bit           found;
        logic [2:0]   fn;
        raw    = {$urandom(), $urandom(), $urandom(), $urandom()};
        it     = raw[$bits(t_item)-1:0];
        pick   = $urandom_range(0, 99);
        p      = $urandom_range(0, POOL_SIZE - 1);
        prefix = yard_prefix();
        if (pick < 4) fn = ($urandom_range(0, 1) == 0) ? FN_SPARE_LO : FN_SPARE_HI;
        else if (pick < 34) fn = FN_ADD;
        else if (pick < 46) fn = FN_ADD_YARD;
        else if (pick < 54) fn = FN_LOAD_YARD;
        else if (pick < 72) fn = FN_REMOVE;
        else if (pick < 78 && map_w * map_h <= 4096) fn = FN_CLEAN;
        else fn = FN_QUERY;

        // remove only owners whose corner is stored
        if (fn == FN_REMOVE) begin
            found = corner_set[owner_pool[p]];
            for (int t = 0; t < POOL_SIZE && !found; t++) begin
                p = (p + 1) % POOL_SIZE;
                found = corner_set[owner_pool[p]];
            end
            if (!found) fn = FN_ADD;
        end
        if (fn == FN_ADD_YARD && prefix == 0) fn = FN_LOAD_YARD;
        it.func = fn;

        case (fn)
            FN_ADD, FN_ADD_YARD: begin
                if ($urandom_range(0, 99) < 85) it.owner_id = owner_pool[p];
                if ($urandom_range(0, 99) < 80) it.corner_x = 8'($urandom_range(0, map_w - 1));
                if ($urandom_range(0, 99) < 80) it.corner_z = 8'($urandom_range(0, map_h - 1));
                it.size_x = random_side();
                if (fn == FN_ADD_YARD && prefix < YARD_SIDE)
                    it.size_z = 6'($urandom_range(0, prefix));
                else
                    it.size_z = random_side();
                if (it.owner_id == owner_pool[p]) begin
                    pool_sx[p] = it.size_x;
                    pool_sz[p] = it.size_z;
                end
                last_x = it.corner_x;
                last_z = it.corner_z;
            end
            FN_LOAD_YARD: begin
                if (prefix < YARD_SIDE && $urandom_range(0, 9) < 6)
                    it.yard_row = 5'(prefix);
                pick = $urandom_range(0, 99);
                if (pick < 15) it.yard_bits = '1;
                else if (pick < 25) it.yard_bits = '0;
            end
            FN_REMOVE: begin
                it.owner_id = owner_pool[p];
                if ($urandom_range(0, 1) == 0) begin
                    it.size_x = pool_sx[p];
                    it.size_z = pool_sz[p];
                end else begin
                    it.size_x = random_side();
                    it.size_z = random_side();
                end
            end
            FN_CLEAN: begin
                it.owner_id = owner_pool[p];
            end
            FN_QUERY: begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    it.cell_index = 16'((last_z + $urandom_range(0, 3)) * map_w
                                        + last_x + $urandom_range(0, 3));
                else if (pick < 85)
                    it.cell_index = 16'($urandom_range(0, map_w * map_h - 1));
            end
            default: ;
        endcase
        return it;
    endfunction

    // Present one item and hold it until the block takes it. Random gaps come
    // first; start is assigned once per edge, so back-to-back items keep it high.
    task automatic send_item(t_item it);
        while (idle_on && $urandom_range(0, 99) < 28) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        if (it.func == FN_ADD || it.func == FN_ADD_YARD) corner_set[it.owner_id] = 1'b1;
        if (it.func == FN_LOAD_YARD) yard_loaded[it.yard_row] = 1'b1;
    endtask

    // Stop sending and wait until every outstanding item has returned. The
    // first edge lets the checker's count catch up with the last accept.
    task automatic wait_all_done();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Both size registers on consecutive edges; the block is idle here.
    // Values out of 1..256 saturate in the block, so track that too.
    task automatic set_map(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAP_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx  <= CFG_MAP_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we   <= 1'b0;
        map_w = (w == 0) ? 1 : ((w > MAX_SIDE_DEF) ? MAX_SIDE_DEF : w);
        map_h = (h == 0) ? 1 : ((h > MAX_SIDE_DEF) ? MAX_SIDE_DEF : h);
    endtask

    task automatic run_random(int n, bit hold_mid);
        for (int i = 0; i < n; i++) begin
            if (hold_mid && i == n / 2) wait_all_done();
            send_item(random_item());
        end
    endtask

    // Directed opening on the full 256x256 map left by reset
    task automatic run_directed();
        // empty grid: owner zero counts every cell, 65536, which needs all 17 bits
        send_item(cmd(FN_CLEAN, 12'd0, 8'd0, 8'd0, 6'd1, 6'd1, 1'b0, 1'b0));
        send_item(query_cmd(16'd0));
        send_item(yard_cmd(5'd0, 32'hffff_ffff));
        send_item(yard_cmd(5'd1, 32'h0000_0000));
        send_item(yard_cmd(5'd2, 32'haaaa_5555));
        send_item(yard_cmd(5'd3, 32'h8000_0001));
        send_item(cmd(FN_ADD, 12'hfff, 8'd0, 8'd0, 6'd1, 6'd1, 1'b0, 1'b1));
        // far corner: mostly off the map, rectangle end reaches 287
        send_item(cmd(FN_ADD, 12'd1, 8'd255, 8'd255, 6'd32, 6'd32, 1'b0, 1'b1));
        // immobile odd corner rounds down; size 63 saturates
        send_item(cmd(FN_ADD, 12'd2, 8'd5, 8'd7, 6'd63, 6'd63, 1'b1, 1'b1));
        // lands on owner 2's cells, which stay taken
        send_item(cmd(FN_ADD, 12'd3, 8'd10, 8'd10, 6'd4, 6'd4, 1'b0, 1'b0));
        send_item(cmd(FN_ADD_YARD, 12'd4, 8'd100, 8'd100, 6'd32, 6'd4, 1'b0, 1'b1));
        // zero width: empty footprint, rectangle still reported
        send_item(cmd(FN_ADD, 12'd5, 8'd20, 8'd200, 6'd0, 6'd5, 1'b1, 1'b1));
        // owner zero: add and remove change nothing
        send_item(cmd(FN_ADD, 12'd0, 8'd50, 8'd50, 6'd3, 6'd3, 1'b0, 1'b1));
        send_item(cmd(FN_REMOVE, 12'd0, 8'd0, 8'd0, 6'd3, 6'd3, 1'b0, 1'b1));
        send_item(query_cmd(16'd65535));
        send_item(query_cmd(16'd1540));
        send_item(query_cmd(16'd2570));
        send_item(cmd(FN_REMOVE, 12'd2, 8'd0, 8'd0, 6'd40, 6'd32, 1'b0, 1'b1));
        send_item(query_cmd(16'd1540));
        send_item(query_cmd(16'd25700));
        send_item(query_cmd(16'd25701));
        send_item(query_cmd(16'd25956));
        send_item(cmd(FN_SPARE_LO, 12'd7, 8'd1, 8'd1, 6'd2, 6'd2, 1'b0, 1'b1));
        send_item(cmd(FN_SPARE_HI, 12'hfff, 8'd255, 8'd255, 6'd63, 6'd63, 1'b1, 1'b1));
        send_item(cmd(FN_REMOVE, 12'd3, 8'd0, 8'd0, 6'd4, 6'd4, 1'b0, 1'b0));
    endtask

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAIL footprint_occupancy_grid");
        $finish;
    end

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            owner_pool[i] = (i < 6) ? OWNER_W'(i) : OWNER_W'($urandom_range(6, 4094));
            pool_sx[i]    = 6'd4;
            pool_sz[i]    = 6'd4;
        end
        owner_pool[6] = 12'hfff;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // the clearing pass after reset shows up as busy; send_item waits it out
        run_directed();
        run_random(40, 1'b0);

        // width and height of zero saturate to a single cell
        wait_all_done();
        set_map(9'd0, 9'd0);
        run_random(40, 1'b0);

        // 511 saturates to 256: one full-width row
        wait_all_done();
        set_map(9'd511, 9'd1);
        run_random(60, 1'b0);

        wait_all_done();
        set_map(9'd1, 9'd256);
        run_random(60, 1'b0);

        // small random maps, where clean is cheap; one phase without gaps and
        // one with a hold-off until everything has returned
        for (int k = 0; k < 5; k++) begin
            wait_all_done();
            set_map(9'($urandom_range(2, 64)), 9'($urandom_range(2, 64)));
            idle_on = (k != 2);
            run_random(60, k == 1);
        end
        idle_on = 1'b1;

        // back to the full map, height written out of range
        wait_all_done();
        set_map(9'd256, 9'd300);
        run_random(60, 1'b0);

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS footprint_occupancy_grid");
        end else begin
            $display("FAIL footprint_occupancy_grid");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/fog_pkg.sv
src/fog_grid.sv
src/footprint_occupancy_grid.sv
verif/fog_checker.sv
verif/footprint_occupancy_grid_tb.sv
